### src/vna_pkg.sv
`default_nettype none
package vna_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int POS_W = 16;
   localparam int DIFF_W = POS_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int ACC_W = 52;
   localparam int CNT_W = 16;
   localparam int NRM_W = 16;
   localparam int T_W = 24;
   localparam int SQ_W = 2 * T_W + 2;
   localparam int ROOT_W = T_W + 1;
   localparam int FRAC_W = 14;
   localparam int QUO_W = 16;
   localparam int NUM_W = T_W + FRAC_W + 1;
   localparam logic [QUO_W-1:0] NRM_ONE = QUO_W'(1 << FRAC_W);

   typedef enum logic [1:0] {
      OP_WRITE_POS = 2'd0,
      OP_ADD_TRI   = 2'd1,
      OP_READ_NRM  = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   typedef logic [IDX_W-1:0]          idx_type;
   typedef logic signed [POS_W-1:0]   pos_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [CROSS_W-1:0] cross_type;
   typedef logic signed [NRM_W-1:0]   nrm_type;

   typedef struct packed {
      logic    we;
      idx_type addr;
      pos_type x;
      pos_type y;
      pos_type z;
   } pos_wr_type;

   typedef struct packed {
      logic    start;
      idx_type a;
      idx_type b;
      idx_type c;
   } face_cmd_type;

   typedef struct packed {
      logic      done;
      cross_type x;
      cross_type y;
      cross_type z;
   } face_res_type;

   typedef struct packed {
      acc_type          sx;
      acc_type          sy;
      acc_type          sz;
      logic [CNT_W-1:0] cnt;
   } acc_entry_type;

   typedef struct packed {
      logic    start;
      acc_type sx;
      acc_type sy;
      acc_type sz;
   } nrm_cmd_type;

   typedef struct packed {
      logic    done;
      nrm_type nx;
      nrm_type ny;
      nrm_type nz;
   } nrm_res_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FACE,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_NRM_RD,
      ST_NRM_GO,
      ST_NRM_WAIT,
      ST_RSP
   } seq_state_type;

   typedef enum logic [2:0] {
      FC_IDLE,
      FC_RD_B,
      FC_RD_C,
      FC_DIFF,
      FC_MUL
   } face_state_type;

   typedef enum logic [2:0] {
      NM_IDLE,
      NM_SHIFT,
      NM_SQ,
      NM_ROOT,
      NM_DSET,
      NM_DIV
   } nrm_state_type;

endpackage
`default_nettype wire

### src/vna_req_if.sv
`default_nettype none
interface vna_req_if import vna_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              op;
   logic [IDX_W-1:0]        vertex_index;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;
   logic [IDX_W-1:0]        corner_a;
   logic [IDX_W-1:0]        corner_b;
   logic [IDX_W-1:0]        corner_c;

   modport source (output valid, op, vertex_index, pos_x, pos_y, pos_z,
                   corner_a, corner_b, corner_c, input ready);
   modport sink (input valid, op, vertex_index, pos_x, pos_y, pos_z,
                 corner_a, corner_b, corner_c, output ready);
endinterface
`default_nettype wire

### src/vna_rsp_if.sv
`default_nettype none
interface vna_rsp_if import vna_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        out_index;
   logic signed [NRM_W-1:0] normal_x;
   logic signed [NRM_W-1:0] normal_y;
   logic signed [NRM_W-1:0] normal_z;
   logic                    has_faces;

   modport source (output valid, out_index, normal_x, normal_y, normal_z, has_faces,
                   input ready);
   modport sink (input valid, out_index, normal_x, normal_y, normal_z, has_faces,
                 output ready);
endinterface
`default_nettype wire

### src/vertex_normal_accumulator.sv
`default_nettype none
// channel   dir  handshake      beat
// req_ch    in   valid/ready    op, vertex_index, pos_x/y/z, corner_a/b/c
// rsp_ch    out  valid/ready    out_index, normal_x/y/z, has_faces (read only)
//
// Triangle add: three position reads, six products on one 17x17 multiplier, then a
// read and a write-back per corner.
// Normal read: shift search, a 25-step square root and three divides.
// Reset and the clear op sweep all entries of the accumulator memory; no beat is taken
// during the sweep.
// A held result stalls only the next read; other beats are taken under it.
module vertex_normal_accumulator import vna_pkg::*; (
   input logic       clock,
   input logic       reset,
   vna_req_if.sink   req_ch,
   vna_rsp_if.source rsp_ch
);

   localparam idx_type CLR_LAST = idx_type'(MAX_VERTICES - 1);

   seq_state_type state_ff, state_in;
   idx_type clr_addr_ff, clr_addr_in;
   logic [1:0] k_ff, k_in;
   idx_type corner_ff [3];
   idx_type vidx_ff;
   logic faces_ff;

   acc_entry_type acc_mem [MAX_VERTICES];
   acc_entry_type acc_rd_ff;
   acc_entry_type acc_wr_data;
   idx_type acc_rd_addr;
   idx_type acc_wr_addr;
   logic acc_we;

   logic accept;
   op_type op;
   pos_wr_type pos_wr;
   face_cmd_type face_cmd;
   face_res_type face_res;
   nrm_cmd_type nrm_cmd;
   nrm_res_type nrm_res;
   logic nrm_start;
   logic rsp_load;

   logic rsp_valid_ff;
   idx_type rsp_index_ff;
   nrm_type rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic rsp_faces_ff;

   function automatic acc_type sat_add(input acc_type a, input cross_type d);
      logic signed [ACC_W:0] s;
      s = (ACC_W+1)'(a) + (ACC_W+1)'(d);
      if (s[ACC_W] != s[ACC_W-1]) begin
         sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sat_add = s[ACC_W-1:0];
      end
   endfunction

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign op           = op_type'(req_ch.op);

   always_comb begin
      pos_wr.we   = accept && (op == OP_WRITE_POS);
      pos_wr.addr = req_ch.vertex_index;
      pos_wr.x    = req_ch.pos_x;
      pos_wr.y    = req_ch.pos_y;
      pos_wr.z    = req_ch.pos_z;
      face_cmd.start = accept && (op == OP_ADD_TRI);
      face_cmd.a     = req_ch.corner_a;
      face_cmd.b     = req_ch.corner_b;
      face_cmd.c     = req_ch.corner_c;
      nrm_cmd.start = nrm_start;
      nrm_cmd.sx = acc_rd_ff.sx;
      nrm_cmd.sy = acc_rd_ff.sy;
      nrm_cmd.sz = acc_rd_ff.sz;
   end

   vna_face u_face (
      .clock  (clock),
      .reset  (reset),
      .pos_wr (pos_wr),
      .cmd    (face_cmd),
      .res    (face_res)
   );

   vna_norm u_norm (
      .clock (clock),
      .reset (reset),
      .cmd   (nrm_cmd),
      .res   (nrm_res)
   );

   always_ff @(posedge clock) begin
      acc_rd_ff <= acc_mem[acc_rd_addr];
      if (acc_we) begin
         acc_mem[acc_wr_addr] <= acc_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         vidx_ff      <= req_ch.vertex_index;
         corner_ff[0] <= req_ch.corner_a;
         corner_ff[1] <= req_ch.corner_b;
         corner_ff[2] <= req_ch.corner_c;
      end
      if (state_ff == ST_NRM_GO) begin
         faces_ff <= (acc_rd_ff.cnt != '0);
      end
      if (rsp_load) begin
         rsp_index_ff <= vidx_ff;
         rsp_x_ff     <= nrm_res.nx;
         rsp_y_ff     <= nrm_res.ny;
         rsp_z_ff     <= nrm_res.nz;
         rsp_faces_ff <= faces_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         k_ff        <= k_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      k_in          = k_ff;
      acc_rd_addr   = vidx_ff;
      acc_we        = 1'b0;
      acc_wr_addr   = clr_addr_ff;
      acc_wr_data   = '0;
      nrm_start     = 1'b0;
      rsp_load      = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            acc_we      = 1'b1;
            clr_addr_in = clr_addr_ff + idx_type'(1);
            if (clr_addr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: if (accept) begin
            case (op)
               OP_ADD_TRI:  state_in = ST_FACE;
               OP_READ_NRM: state_in = ST_NRM_RD;
               OP_CLEAR: begin
                  state_in    = ST_CLEAR;
                  clr_addr_in = '0;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_FACE: if (face_res.done) begin
            state_in = ST_ACC_RD;
            k_in     = '0;
         end
         ST_ACC_RD: begin
            acc_rd_addr = corner_ff[k_ff];
            state_in    = ST_ACC_WR;
         end
         ST_ACC_WR: begin
            // write back before the next corner is read, so repeats see it
            acc_we          = 1'b1;
            acc_wr_addr     = corner_ff[k_ff];
            acc_wr_data.sx  = sat_add(acc_rd_ff.sx, face_res.x);
            acc_wr_data.sy  = sat_add(acc_rd_ff.sy, face_res.y);
            acc_wr_data.sz  = sat_add(acc_rd_ff.sz, face_res.z);
            acc_wr_data.cnt = acc_rd_ff.cnt + CNT_W'(acc_rd_ff.cnt != '1);
            if (k_ff == 2'd2) begin
               state_in = ST_IDLE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_ACC_RD;
            end
         end
         ST_NRM_RD: state_in = ST_NRM_GO;
         ST_NRM_GO: begin
            nrm_start = 1'b1;
            state_in  = ST_NRM_WAIT;
         end
         ST_NRM_WAIT: if (nrm_res.done) begin
            state_in = ST_RSP;
         end
         ST_RSP: if (!rsp_valid_ff || rsp_ch.ready) begin
            rsp_load = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_index = rsp_index_ff;
   assign rsp_ch.normal_x  = rsp_x_ff;
   assign rsp_ch.normal_y  = rsp_y_ff;
   assign rsp_ch.normal_z  = rsp_z_ff;
   assign rsp_ch.has_faces = rsp_faces_ff;

`ifndef SYNTHESIS
   a_sweep_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (state_ff == ST_CLEAR && clr_addr_ff == '0))
      else $error("accumulator sweep did not start after reset");

   a_face_done_wait: assert property (@(posedge clock) disable iff (reset)
      face_res.done |-> state_ff == ST_FACE)
      else $error("cross product finished outside triangle wait");

   a_norm_done_wait: assert property (@(posedge clock) disable iff (reset)
      nrm_res.done |-> state_ff == ST_NRM_WAIT)
      else $error("normalize finished outside read wait");

   a_corner_range: assert property (@(posedge clock) disable iff (reset)
      k_ff != 2'd3)
      else $error("corner counter out of range");
`endif

endmodule
`default_nettype wire

### src/vna_face.sv
`default_nettype none
module vna_face import vna_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  pos_wr_type   pos_wr,
   input  face_cmd_type cmd,
   output face_res_type res
);

   localparam logic [2:0] STEP_LAST = 3'd6;

   logic [3*POS_W-1:0] pos_mem [MAX_VERTICES];
   logic [3*POS_W-1:0] rd_data_ff;
   logic [3*POS_W-1:0] pa_ff;
   idx_type rd_addr;
   idx_type b_ff;
   idx_type c_ff;

   face_state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic done_ff, done_in;

   logic signed [DIFF_W-1:0] u_ff [3];
   logic signed [DIFF_W-1:0] w_ff [3];
   logic signed [DIFF_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] hold_ff;
   cross_type cross_ff [3];

   function automatic pos_type fld(input logic [3*POS_W-1:0] p, input int k);
      fld = pos_type'(p[(2-k)*POS_W +: POS_W]);
   endfunction

   function automatic logic signed [DIFF_W-1:0] pdiff(input pos_type p, input pos_type q);
      pdiff = DIFF_W'(p) - DIFF_W'(q);
   endfunction

   always_ff @(posedge clock) begin
      rd_data_ff <= pos_mem[rd_addr];
      if (pos_wr.we) begin
         pos_mem[pos_wr.addr] <= {pos_wr.x, pos_wr.y, pos_wr.z};
      end
   end

   always_comb begin
      case (state_ff)
         FC_RD_B: rd_addr = b_ff;
         FC_RD_C: rd_addr = c_ff;
         default: rd_addr = cmd.a;
      endcase
   end

   // products in order: uy*wz, uz*wy, uz*wx, ux*wz, ux*wy, uy*wx
   always_comb begin
      case (step_ff)
         3'd0: begin mul_a = u_ff[1]; mul_b = w_ff[2]; end
         3'd1: begin mul_a = u_ff[2]; mul_b = w_ff[1]; end
         3'd2: begin mul_a = u_ff[2]; mul_b = w_ff[0]; end
         3'd3: begin mul_a = u_ff[0]; mul_b = w_ff[2]; end
         3'd4: begin mul_a = u_ff[0]; mul_b = w_ff[1]; end
         default: begin mul_a = u_ff[1]; mul_b = w_ff[0]; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == FC_IDLE && cmd.start) begin
         b_ff <= cmd.b;
         c_ff <= cmd.c;
      end
      if (state_ff == FC_RD_B) begin
         pa_ff <= rd_data_ff;
      end
      if (state_ff == FC_RD_C) begin
         for (int k = 0; k < 3; k++) begin
            u_ff[k] <= pdiff(fld(rd_data_ff, k), fld(pa_ff, k));
         end
      end
      if (state_ff == FC_DIFF) begin
         for (int k = 0; k < 3; k++) begin
            w_ff[k] <= pdiff(fld(rd_data_ff, k), fld(pa_ff, k));
         end
      end
      if (state_ff == FC_MUL) begin
         prod_ff <= mul_a * mul_b;
         // fold the product of the previous step
         if (step_ff[0]) begin
            hold_ff <= prod_ff;
         end else if (step_ff != 3'd0) begin
            cross_ff[step_ff[2:1] - 2'd1] <= CROSS_W'(hold_ff) - CROSS_W'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FC_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      case (state_ff)
         FC_IDLE: if (cmd.start) begin
            state_in = FC_RD_B;
         end
         FC_RD_B: state_in = FC_RD_C;
         FC_RD_C: state_in = FC_DIFF;
         FC_DIFF: begin
            state_in = FC_MUL;
            step_in  = '0;
         end
         FC_MUL: begin
            step_in = step_ff + 3'd1;
            if (step_ff == STEP_LAST) begin
               state_in = FC_IDLE;
               step_in  = '0;
               done_in  = 1'b1;
            end
         end
         default: state_in = FC_IDLE;
      endcase
   end

   assign res.done = done_ff;
   assign res.x    = cross_ff[0];
   assign res.y    = cross_ff[1];
   assign res.z    = cross_ff[2];

endmodule
`default_nettype wire

### src/vna_norm.sv
`default_nettype none
module vna_norm import vna_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  nrm_cmd_type cmd,
   output nrm_res_type res
);

   localparam logic [SQ_W-1:0] ROOT_START = SQ_W'(1) << (SQ_W - 2);
   localparam logic [3:0] DIV_LAST = 4'd15;

   nrm_state_type state_ff, state_in;
   logic done_ff, done_in;

   logic [ACC_W-1:0] t_ff [3];
   logic [2:0] neg_ff;
   logic [1:0] k_ff;
   logic [SQ_W-1:0] sq_ff;
   logic [SQ_W-1:0] n_ff;
   logic [SQ_W-1:0] root_ff;
   logic [SQ_W-1:0] bit_ff;
   logic [ROOT_W-1:0] rem_ff;
   logic [QUO_W-1:0] lo_ff;
   logic [QUO_W-1:0] q_ff;
   logic [3:0] cnt_ff;
   nrm_type out_ff [3];

   logic [ACC_W-1:0] or_all;
   logic [ACC_W-1:0] t_sel;
   logic [2*T_W-1:0] sq_prod;
   logic [SQ_W:0] root_trial;
   logic root_take;
   logic [ROOT_W-1:0] r_val;
   logic [NUM_W-1:0] num;
   logic [ROOT_W:0] div_trial;
   logic div_take;
   logic [QUO_W-1:0] q_next;
   logic [QUO_W-1:0] q_clamp;
   nrm_type nrm_val;

   function automatic logic [ACC_W-1:0] mag(input acc_type s);
      mag = s[ACC_W-1] ? ACC_W'(-s) : ACC_W'(s);
   endfunction

   always_comb begin
      or_all     = t_ff[0] | t_ff[1] | t_ff[2];
      t_sel      = t_ff[k_ff];
      sq_prod    = t_sel[T_W-1:0] * t_sel[T_W-1:0];
      root_trial = (SQ_W+1)'(root_ff) + (SQ_W+1)'(bit_ff);
      root_take  = {1'b0, n_ff} >= root_trial;
      r_val      = root_ff[ROOT_W-1:0];
      num        = (NUM_W'(t_sel[T_W-1:0]) << FRAC_W) + NUM_W'(r_val >> 1);
      div_trial  = {rem_ff, lo_ff[QUO_W-1]};
      div_take   = div_trial >= (ROOT_W+1)'(r_val);
      q_next     = {q_ff[QUO_W-2:0], div_take};
      q_clamp    = (q_next > NRM_ONE) ? NRM_ONE : q_next;
      nrm_val    = neg_ff[k_ff] ? nrm_type'(-q_clamp) : nrm_type'(q_clamp);
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         NM_IDLE: if (cmd.start) begin
            t_ff[0] <= mag(cmd.sx);
            t_ff[1] <= mag(cmd.sy);
            t_ff[2] <= mag(cmd.sz);
            neg_ff  <= {cmd.sz[ACC_W-1], cmd.sy[ACC_W-1], cmd.sx[ACC_W-1]};
         end
         NM_SHIFT: begin
            // bring the leading one of the largest magnitude to the top of T_W
            if (or_all == '0) begin
               for (int k = 0; k < 3; k++) out_ff[k] <= '0;
            end else if (|or_all[ACC_W-1:T_W]) begin
               for (int k = 0; k < 3; k++) t_ff[k] <= t_ff[k] >> 1;
            end else if (!or_all[T_W-1]) begin
               for (int k = 0; k < 3; k++) t_ff[k] <= t_ff[k] << 1;
            end else begin
               k_ff  <= '0;
               sq_ff <= '0;
            end
         end
         NM_SQ: begin
            sq_ff <= sq_ff + SQ_W'(sq_prod);
            if (k_ff == 2'd2) begin
               n_ff    <= sq_ff + SQ_W'(sq_prod);
               root_ff <= '0;
               bit_ff  <= ROOT_START;
               k_ff    <= '0;
            end else begin
               k_ff <= k_ff + 2'd1;
            end
         end
         NM_ROOT: begin
            if (root_take) begin
               n_ff    <= n_ff - root_trial[SQ_W-1:0];
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         NM_DSET: begin
            rem_ff <= ROOT_W'(num >> QUO_W);
            lo_ff  <= num[QUO_W-1:0];
            q_ff   <= '0;
            cnt_ff <= '0;
         end
         NM_DIV: begin
            rem_ff <= div_take ? ROOT_W'(div_trial - (ROOT_W+1)'(r_val))
                               : div_trial[ROOT_W-1:0];
            lo_ff  <= lo_ff << 1;
            q_ff   <= q_next;
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == DIV_LAST) begin
               out_ff[k_ff] <= nrm_val;
               k_ff         <= k_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      case (state_ff)
         NM_IDLE: if (cmd.start) begin
            state_in = NM_SHIFT;
         end
         NM_SHIFT: begin
            if (or_all == '0) begin
               state_in = NM_IDLE;
               done_in  = 1'b1;
            end else if (!(|or_all[ACC_W-1:T_W]) && or_all[T_W-1]) begin
               state_in = NM_SQ;
            end
         end
         NM_SQ: if (k_ff == 2'd2) begin
            state_in = NM_ROOT;
         end
         NM_ROOT: if (bit_ff[0]) begin
            state_in = NM_DSET;
         end
         NM_DSET: state_in = NM_DIV;
         NM_DIV: if (cnt_ff == DIV_LAST) begin
            if (k_ff == 2'd2) begin
               state_in = NM_IDLE;
               done_in  = 1'b1;
            end else begin
               state_in = NM_DSET;
            end
         end
         default: state_in = NM_IDLE;
      endcase
   end

   assign res.done = done_ff;
   assign res.nx   = out_ff[0];
   assign res.ny   = out_ff[1];
   assign res.nz   = out_ff[2];

endmodule
`default_nettype wire

### tb/sv/vna_tb_if.sv
`timescale 1ns / 1ps
// The block's channel interfaces are declared with the RTL sources.
// Nothing further is needed here.
package vna_tb_types;
   import vna_pkg::*;

   typedef struct {
      logic [IDX_W-1:0] index;
      logic [15:0]      nx;
      logic [15:0]      ny;
      logic [15:0]      nz;
      logic             faces;
   } normal_beat;
endpackage

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import vna_pkg::*;
   import vna_tb_types::*;

   localparam longint SUM_MAX = 64'sd2251799813685247;
   localparam longint SUM_MIN = -SUM_MAX - 1;
   localparam int STALL_LIMIT = 20000;

   class normal_scoreboard;
      logic signed [15:0] px[MAX_VERTICES];
      logic signed [15:0] py[MAX_VERTICES];
      logic signed [15:0] pz[MAX_VERTICES];
      longint sx[MAX_VERTICES];
      longint sy[MAX_VERTICES];
      longint sz[MAX_VERTICES];
      int unsigned cnt[MAX_VERTICES];
      normal_beat pending[$];
      int mismatches;

      function new();
         for (int i = 0; i < MAX_VERTICES; i++) begin
            px[i] = 0; py[i] = 0; pz[i] = 0;
         end
         clear_sums();
         mismatches = 0;
      endfunction

      function void clear_sums();
         for (int i = 0; i < MAX_VERTICES; i++) begin
            sx[i] = 0; sy[i] = 0; sz[i] = 0; cnt[i] = 0;
         end
      endfunction

      function longint sat(longint acc, longint d);
         longint s;
         s = acc + d;
         if (s > SUM_MAX) return SUM_MAX;
         if (s < SUM_MIN) return SUM_MIN;
         return s;
      endfunction

      function void add_corner(int v, longint cx, longint cy, longint cz);
         sx[v] = sat(sx[v], cx);
         sy[v] = sat(sy[v], cy);
         sz[v] = sat(sz[v], cz);
         if (cnt[v] < 65535) cnt[v]++;
      endfunction

      function longint unsigned root(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n -= r + b;
               r = (r >> 1) + b;
            end else
               r >>= 1;
            b >>= 2;
         end
         return r;
      endfunction

      function logic [15:0] scale(longint s, longint unsigned t, longint unsigned r);
         longint unsigned q;
         q = (t * 16384 + (r >> 1)) / r;
         if (q > 16384) q = 16384;
         return s < 0 ? 16'(-q) : 16'(q);
      endfunction

      function void note_beat(op_type op, int vi, logic signed [15:0] x,
                              logic signed [15:0] y, logic signed [15:0] z,
                              int a, int b, int c);
         longint ux, uy, uz, wx, wy, wz, cx, cy, cz;
         longint unsigned tx, ty, tz, m, r;
         int p;
         normal_beat e;
         case (op)
            OP_WRITE_POS: begin
               px[vi] = x; py[vi] = y; pz[vi] = z;
            end
            OP_ADD_TRI: begin
               ux = px[b] - px[a]; uy = py[b] - py[a]; uz = pz[b] - pz[a];
               wx = px[c] - px[a]; wy = py[c] - py[a]; wz = pz[c] - pz[a];
               cx = uy * wz - uz * wy;
               cy = uz * wx - ux * wz;
               cz = ux * wy - uy * wx;
               add_corner(a, cx, cy, cz);
               add_corner(b, cx, cy, cz);
               add_corner(c, cx, cy, cz);
            end
            OP_CLEAR: clear_sums();
            default: begin
               e.index = IDX_W'(vi);
               e.nx = '0; e.ny = '0; e.nz = '0;
               e.faces = cnt[vi] != 0;
               tx = sx[vi] < 0 ? -sx[vi] : sx[vi];
               ty = sy[vi] < 0 ? -sy[vi] : sy[vi];
               tz = sz[vi] < 0 ? -sz[vi] : sz[vi];
               m = tx;
               if (ty > m) m = ty;
               if (tz > m) m = tz;
               if (m != 0) begin
                  p = 0;
                  while (p < 63 && (m >> (p + 1)) != 0) p++;
                  if (p > 23) begin
                     tx >>= p - 23; ty >>= p - 23; tz >>= p - 23;
                  end else begin
                     tx <<= 23 - p; ty <<= 23 - p; tz <<= 23 - p;
                  end
                  r = root(tx * tx + ty * ty + tz * tz);
                  if (r == 0) r = 1;
                  e.nx = scale(sx[vi], tx, r);
                  e.ny = scale(sy[vi], ty, r);
                  e.nz = scale(sz[vi], tz, r);
               end
               pending = {pending, e};
            end
         endcase
      endfunction

      function void check_beat(normal_beat got);
         normal_beat e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected normal for vertex %0d", got.index);
            return;
         end
         e = pending.pop_front();
         if (got.index !== e.index || got.nx !== e.nx || got.ny !== e.ny ||
             got.nz !== e.nz || got.faces !== e.faces) begin
            mismatches++;
            if (mismatches <= 10)
               $display("normal mismatch: exp %0d %h %h %h %b, got %0d %h %h %h %b",
                        e.index, e.nx, e.ny, e.nz, e.faces,
                        got.index, got.nx, got.ny, got.nz, got.faces);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   vna_req_if req_ch();
   vna_rsp_if rsp_ch();

   vertex_normal_accumulator dut (.clock(clock), .reset(reset),
                                  .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source));

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   normal_scoreboard normals = new();
   bit written[MAX_VERTICES];
   int nwritten;
   int idle_cycles;
   bit hold_rsp;
   bit stim_done;
   int rsp_seen;

   initial begin
      req_ch.valid = 0; req_ch.op = 0; req_ch.vertex_index = 0;
      req_ch.pos_x = 0; req_ch.pos_y = 0; req_ch.pos_z = 0;
      req_ch.corner_a = 0; req_ch.corner_b = 0; req_ch.corner_c = 0;
      rsp_ch.ready = 0;
   end

   // note beats and check results at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            normals.note_beat(op_type'(req_ch.op), req_ch.vertex_index, req_ch.pos_x,
                              req_ch.pos_y, req_ch.pos_z, req_ch.corner_a,
                              req_ch.corner_b, req_ch.corner_c);
         if (rsp_ch.valid && rsp_ch.ready) begin
            normal_beat g;
            g.index = rsp_ch.out_index; g.nx = rsp_ch.normal_x;
            g.ny = rsp_ch.normal_y; g.nz = rsp_ch.normal_z; g.faces = rsp_ch.has_faces;
            normals.check_beat(g);
            rsp_seen++;
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver stall pattern, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_rsp)
         rsp_ch.ready <= 1'b0;
      else
         case (($urandom_range(0, 999) / 250))
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= $urandom_range(0, 3) != 0;
            2: rsp_ch.ready <= $urandom_range(0, 1) != 0;
            default: rsp_ch.ready <= $urandom_range(0, 4) == 0;
         endcase
   end

   initial begin
      hold_rsp = 0;
      wait (stim_done == 0 && rsp_seen > 20);
      hold_rsp = 1;
      repeat (1500) @(posedge clock);
      hold_rsp = 0;
   end

   int burst_left;

   task automatic send(op_type op, int vi, int x, int y, int z, int a, int b, int c);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.vertex_index <= IDX_W'(vi);
      req_ch.pos_x <= 16'(x); req_ch.pos_y <= 16'(y); req_ch.pos_z <= 16'(z);
      req_ch.corner_a <= IDX_W'(a); req_ch.corner_b <= IDX_W'(b);
      req_ch.corner_c <= IDX_W'(c);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      if (op == OP_WRITE_POS && !written[vi]) begin
         written[vi] = 1;
         nwritten++;
      end
   endtask

   task automatic put_pos(int vi, int x, int y, int z);
      send(OP_WRITE_POS, vi, x, y, z, $urandom_range(0, 1023),
           $urandom_range(0, 1023), $urandom_range(0, 1023));
   endtask

   function automatic int pick_written(int hot);
      int v;
      do v = $urandom_range(0, hot - 1); while (!written[v]);
      return v;
   endfunction

   task automatic add_tri(int a, int b, int c);
      send(OP_ADD_TRI, $urandom_range(0, 1023), $urandom(), $urandom(), $urandom(),
           a, b, c);
   endtask

   task automatic read_nrm(int vi);
      send(OP_READ_NRM, vi, $urandom(), $urandom(), $urandom(),
           $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
   endtask

   function automatic int rand_pos();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 32767 : -32768;
         1: return $signed(16'($urandom()));
         default: return $urandom_range(0, 2047) - 1024;
      endcase
   endfunction

   initial begin
      int hot, k;
      stim_done = 0;
      rsp_seen = 0;
      idle_cycles = 0;
      burst_left = 0;
      nwritten = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: extremes, degenerate and repeated corners
      read_nrm(0);
      put_pos(0, -32768, -32768, -32768);
      put_pos(1, 32767, -32768, -32768);
      put_pos(2, -32768, 32767, -32768);
      put_pos(1023, 32767, 32767, 32767);
      add_tri(0, 1, 2);
      read_nrm(0);
      read_nrm(1023);
      add_tri(0, 0, 0);
      read_nrm(0);
      put_pos(3, 0, 0, 0);
      add_tri(3, 3, 1023);
      read_nrm(3);
      for (int i = 0; i < 6; i++) add_tri(2, 1, 0);
      read_nrm(2);
      read_nrm(1);
      send(OP_CLEAR, 1023, 0, 0, 0, 1023, 1023, 1023);
      read_nrm(2);
      add_tri(1023, 1, 2);
      read_nrm(1023);
      // random: writes, triangles and reads, in phases that favour a small set of vertices, occasional clears
      for (int n = 0; n < 1080; n++) begin
         hot = (n % 300 < 150) ? 16 : 1024;
         k = $urandom_range(0, 99);
         if (k < 20 || nwritten < 3)
            put_pos((nwritten < 3 || k < 10) ? $urandom_range(0, 1023)
                    : $urandom_range(0, 15), rand_pos(), rand_pos(), rand_pos());
         else if (k < 60)
            add_tri(pick_written(written[0] ? hot : 1024), pick_written(1024),
                    pick_written(hot));
         else if (k < 98)
            read_nrm($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 1023));
         else
            send(OP_CLEAR, $urandom_range(0, 1023), 0, 0, 0, 0, 0, 0);
      end
      req_ch.valid <= 1'b0;
      stim_done = 1;
      while (normals.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (normals.mismatches == 0 && normals.pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
